### src/vdifhg_pkg.sv
// shared types and constants for the vdif frame header generator
package vdifhg_pkg;

	localparam int MAX_GAP_FRAMES_DEF = 64;

	localparam int SEC_W  = 30;
	localparam int FRM_W  = 24;
	localparam int FPS_W  = 25;
	localparam int FLW_W  = 24;
	localparam int PAY_W  = 27;
	localparam int GAP_W  = 7;
	localparam int CFG_W  = 30;
	localparam int CIDX_W = 2;

	localparam logic [CIDX_W-1:0] CFG_START_SECONDS      = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_START_FRAME        = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_FRAMES_PER_SECOND  = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_FRAME_LENGTH_WORDS = 2'd3;

	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_FILLER = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [31:0] VERSION_BIT  = 32'h2000_0000;
	localparam logic [31:0] WORD3_CONST  = 32'd4;
	localparam logic [FLW_W-1:0] HDR_WORDS = 24'd4;

	typedef struct packed {
		logic             func;
		logic [PAY_W-1:0] payload_bytes;
		logic [GAP_W-1:0] gap_frames;
		logic             gap_filler;
	} in_req_t;

	typedef struct packed {
		logic [31:0] word0;
		logic [31:0] word1;
		logic [31:0] word2;
		logic [31:0] word3;
		logic [1:0]  kind;
		logic        last;
	} out_req_t;

	typedef struct packed {
		logic load;
		logic emit;
		logic advance;
		logic step;
	} dp_cmd_t;

	typedef struct packed {
		logic in_is_gap;
		logic size_ok;
		logic filler;
		logic cnt_zero;
		logic cnt_one;
		logic out_free;
	} dp_status_t;

endpackage

### src/vdifhg_ctrl.sv
// controller state machine sequencing data frames and gap runs
module vdifhg_ctrl
	import vdifhg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DATA = 3'b010,
		ST_GAP  = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_stall    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = status.in_is_gap ? ST_GAP : ST_DATA;
				end
			end
			ST_DATA: begin
				if (status.out_free) begin
					cmd.emit    = 1'b1;
					cmd.advance = status.size_ok;
					state_d     = ST_IDLE;
				end
			end
			ST_GAP: begin
				if (status.cnt_zero) begin
					state_d = ST_IDLE;
				end else if (!status.filler || status.out_free) begin
					cmd.emit    = status.filler;
					cmd.advance = 1'b1;
					cmd.step    = 1'b1;
					if (status.cnt_one) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### src/vdifhg_dp.sv
// datapath: config registers, time counters, item registers and output register
module vdifhg_dp
	import vdifhg_pkg::*;
#(
	parameter int MAX_GAP_FRAMES = MAX_GAP_FRAMES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  in_req_t           in_data,
	input  logic              cfg_valid,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  dp_cmd_t           cmd,
	output dp_status_t        status,
	output logic              out_valid,
	input  logic              out_stall,
	output out_req_t          out_data
);

	localparam int CNT_W = $clog2(MAX_GAP_FRAMES + 1);
	localparam logic [GAP_W-1:0] GAP_MAX = GAP_W'(MAX_GAP_FRAMES);

	logic [SEC_W-1:0] sec_q;
	logic [FRM_W-1:0] frm_q;
	logic [FPS_W-1:0] fps_q;
	logic [FLW_W-1:0] flw_q;

	logic             func_q;
	logic             filler_q;
	logic [PAY_W-1:0] payload_q;
	logic [CNT_W-1:0] cnt_q;

	logic             out_valid_q;
	out_req_t         out_q;

	logic [GAP_W-1:0] gap_sat;
	logic [FPS_W-1:0] frm_nxt;
	logic             wrap;
	logic             size_ok;
	logic             out_free;
	out_req_t         out_d;

	assign gap_sat  = (in_data.gap_frames > GAP_MAX) ? GAP_MAX : in_data.gap_frames;
	assign frm_nxt  = {1'b0, frm_q} + FPS_W'(1);
	assign wrap     = frm_nxt >= fps_q;
	assign size_ok  = (flw_q >= HDR_WORDS) &&
		(payload_q == {flw_q - HDR_WORDS, 3'b000});
	assign out_free = !out_valid_q || !out_stall;

	assign status.in_is_gap = in_data.func;
	assign status.size_ok   = size_ok;
	assign status.filler    = filler_q;
	assign status.cnt_zero  = cnt_q == '0;
	assign status.cnt_one   = cnt_q == CNT_W'(1);
	assign status.out_free  = out_free;

	always_comb begin
		out_d = '0;
		if (func_q) begin
			out_d.kind = KIND_FILLER;
			out_d.last = cnt_q == CNT_W'(1);
		end else if (size_ok) begin
			out_d.word0 = {2'b00, sec_q};
			out_d.word1 = {8'h00, frm_q};
			out_d.word2 = VERSION_BIT | {8'h00, flw_q};
			out_d.word3 = WORD3_CONST;
			out_d.kind  = KIND_DATA;
		end else begin
			out_d.kind = KIND_ERROR;
		end
	end

	// config registers and frame time counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q <= '0;
			frm_q <= '0;
			fps_q <= FPS_W'(1);
			flw_q <= FLW_W'(1004);
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_START_SECONDS:      sec_q <= cfg_data[SEC_W-1:0];
					CFG_START_FRAME:        frm_q <= cfg_data[FRM_W-1:0];
					CFG_FRAMES_PER_SECOND:  fps_q <= cfg_data[FPS_W-1:0];
					CFG_FRAME_LENGTH_WORDS: flw_q <= cfg_data[FLW_W-1:0];
					default: ;
				endcase
			end else if (cmd.advance) begin
				if (wrap) begin
					frm_q <= '0;
					sec_q <= sec_q + SEC_W'(1);
				end else begin
					frm_q <= frm_nxt[FRM_W-1:0];
				end
			end
		end
	end

	// current item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q    <= in_data.func;
			filler_q  <= in_data.gap_filler;
			payload_q <= in_data.payload_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= in_data.func ? CNT_W'(gap_sat) : '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### src/vdif_frame_header_generator.sv
// top level of the vdif frame header generator
// Input channel in_valid/in_stall/in_data carries one request per frame or gap.
// A data request with the right payload size gives one data header and steps the
// frame count; a wrong size gives one error result and leaves the count alone.
// A gap request steps the count once per lost frame, up to MAX_GAP_FRAMES; a
// filler gap also gives one zeroed header per lost frame, the last one marked.
// Results leave on out_valid/out_stall/out_data through one output register.
// A data request is loaded into the item registers on acceptance; its result
// enters the output register once that is free, and only then is the block
// ready again. A gap steps its counter once per cycle, a filler gap only while
// the output register is free, and the block is ready again at count zero.
// While out_stall holds, the stalled result stays put and the sequencer waits
// for the register to free up; a new request may be taken while a result waits.
// Config writes go through cfg_valid/cfg_index/cfg_data, always ready; the user
// must make them only while the block is idle; the block does not enforce it.
// Writing start values reloads counters. Reset sets defaults: start 0, frame 0,
// one frame per second, frame length 1004 words, no result pending.
module vdif_frame_header_generator
	import vdifhg_pkg::*;
#(
	parameter int MAX_GAP_FRAMES = MAX_GAP_FRAMES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_req_t           in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output out_req_t          out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	vdifhg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	vdifhg_dp #(
		.MAX_GAP_FRAMES (MAX_GAP_FRAMES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

### sim/vdif_frame_header_checker.sv
// checker for the vdif frame header generator: predicts headers per request and compares
module vdif_frame_header_checker
	import vdifhg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  in_req_t           in_data,
	input  logic              out_valid,
	input  logic              out_stall,
	input  out_req_t          out_data,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	output int                errors,
	output int                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic FUNC_DATA = 1'b0;

	logic [SEC_W-1:0] sec_cnt;
	logic [FRM_W-1:0] frm_cnt;
	logic [FPS_W-1:0] fps;
	logic [FLW_W-1:0] flen;
	out_req_t         headers_due[$];

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
		errors++;
	endtask

	function automatic void step_frame();
		logic [FRM_W:0] nxt;
		nxt = {1'b0, frm_cnt} + 1'b1;
		// a zero rate wraps on every step, the same as a rate of one
		if (nxt >= fps) begin
			frm_cnt = '0;
			sec_cnt = sec_cnt + 1'b1;
		end else begin
			frm_cnt = nxt[FRM_W-1:0];
		end
	endfunction

	function automatic void predict_headers(input in_req_t r);
		out_req_t h;
		int       lost;
		longint   need;
		h = '0;
		if (r.func == FUNC_DATA) begin
			need = longint'(flen) * 8 - 32;
			if (flen < HDR_WORDS || longint'(r.payload_bytes) != need) begin
				h.kind = KIND_ERROR;
				headers_due.push_back(h);
			end else begin
				h.word0 = {2'b00, sec_cnt};
				h.word1 = {8'h00, frm_cnt};
				h.word2 = VERSION_BIT | {8'h00, flen};
				h.word3 = WORD3_CONST;
				h.kind  = KIND_DATA;
				headers_due.push_back(h);
				step_frame();
			end
		end else begin
			lost = (r.gap_frames > MAX_GAP_FRAMES_DEF) ? MAX_GAP_FRAMES_DEF : r.gap_frames;
			for (int k = 0; k < lost; k++) begin
				if (r.gap_filler) begin
					h.kind = KIND_FILLER;
					h.last = (k == lost - 1);
					headers_due.push_back(h);
				end
				step_frame();
			end
		end
	endfunction

	task automatic check_header(input out_req_t got);
		out_req_t want;
		want = headers_due.pop_front();
		if (got.word0 !== want.word0) report_mismatch("word0", got.word0, want.word0);
		if (got.word1 !== want.word1) report_mismatch("word1", got.word1, want.word1);
		if (got.word2 !== want.word2) report_mismatch("word2", got.word2, want.word2);
		if (got.word3 !== want.word3) report_mismatch("word3", got.word3, want.word3);
		if (got.kind !== want.kind) report_mismatch("kind", 32'(got.kind), 32'(want.kind));
		if (got.last !== want.last) report_mismatch("last", 32'(got.last), 32'(want.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_cnt = '0;
			frm_cnt = '0;
			fps = FPS_W'(1);
			flen = FLW_W'(1004);
			headers_due.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (headers_due.size() == 0)
					report_mismatch("unexpected result, kind", 32'(out_data.kind), 32'h0);
				else
					check_header(out_data);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_START_SECONDS: sec_cnt = cfg_data[SEC_W-1:0];
					CFG_START_FRAME: frm_cnt = cfg_data[FRM_W-1:0];
					CFG_FRAMES_PER_SECOND: fps = cfg_data[FPS_W-1:0];
					CFG_FRAME_LENGTH_WORDS: flen = cfg_data[FLW_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_headers(in_data);
			outstanding = headers_due.size();
		end
	end

endmodule

### sim/tb_vdif_frame_header_generator.sv
// testbench top for the vdif frame header generator: stimulus, stalls and verdict
module tb_vdif_frame_header_generator;
	import vdifhg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic FUNC_DATA     = 1'b0;
	localparam logic FUNC_GAP      = 1'b1;
	localparam int   SETTLE_CYCLES = 80;
	localparam int   CYCLE_LIMIT   = 400000;
	localparam int   RANDOM_PHASES = 5;
	localparam int   PHASE_REQS    = 26;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	in_req_t           in_data;
	logic              out_valid;
	logic              out_stall;
	out_req_t          out_data;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CIDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	int                errors;
	int                outstanding;

	logic [FLW_W-1:0]  cur_flen = FLW_W'(1004);
	bit                quiet = 1'b0;
	int                idle_pct = 0;
	int                stall_pct = 0;
	int                cycles = 0;

	vdif_frame_header_generator i_dut (.*);

	vdif_frame_header_checker i_checker (.*);

	always #10ns clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver stalls in bursts
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic [PAY_W-1:0] good_payload();
		return PAY_W'((int'(cur_flen) << 3) - 32);
	endfunction

	function automatic in_req_t data_req(input logic [PAY_W-1:0] pay);
		in_req_t r;
		r.func = FUNC_DATA;
		r.payload_bytes = pay;
		r.gap_frames = GAP_W'($urandom);
		r.gap_filler = 1'($urandom);
		return r;
	endfunction

	function automatic in_req_t gap_req(input logic [GAP_W-1:0] n, input logic filler);
		in_req_t r;
		r.func = FUNC_GAP;
		r.payload_bytes = PAY_W'($urandom);
		r.gap_frames = n;
		r.gap_filler = filler;
		return r;
	endfunction

	task automatic send_req(input in_req_t r);
		logic taken;
		if (!quiet && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_data <= r;
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	// hold off the sender until every expected header has arrived
	task automatic drain(input int settle);
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		logic taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		if (idx == CFG_FRAME_LENGTH_WORDS)
			cur_flen = val[FLW_W-1:0];
	endtask

	task automatic configure(input logic [CFG_W-1:0] sec_w, input logic [CFG_W-1:0] frm_w,
			input logic [CFG_W-1:0] fps_w, input logic [CFG_W-1:0] flen_w);
		drain(SETTLE_CYCLES);
		cfg_write(CFG_FRAMES_PER_SECOND, fps_w);
		cfg_write(CFG_FRAME_LENGTH_WORDS, flen_w);
		cfg_write(CFG_START_SECONDS, sec_w);
		cfg_write(CFG_START_FRAME, frm_w);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		in_req_t          r;
		int               sel;
		logic [FPS_W-1:0] fps_v;
		logic [FRM_W-1:0] frm_v;
		logic [SEC_W-1:0] sec_v;
		logic [FLW_W-1:0] flen_v;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: one frame per second, 1004 word frames
		send_req(data_req(good_payload()));
		send_req(data_req('0));
		send_req(data_req('1));
		send_req(gap_req(GAP_W'(0), 1'b1));
		send_req(gap_req(GAP_W'(1), 1'b1));
		send_req(gap_req(GAP_W'(3), 1'b0));
		send_req(gap_req('1, 1'b1));
		send_req(gap_req(GAP_W'(MAX_GAP_FRAMES_DEF), 1'b0));
		r = data_req(good_payload());
		r.gap_frames = '1;
		r.gap_filler = 1'b1;
		send_req(r);

		// rate 2^24 and largest length, frame number at its last value near seconds wrap
		configure(CFG_W'(30'h3FFF_FFFE), {6'h3F, 24'hFF_FFFF}, {5'h1F, 25'h100_0000},
			{6'h3F, 24'hFF_FFFF});
		send_req(data_req(good_payload()));
		send_req(data_req(good_payload()));
		r = gap_req(GAP_W'(2), 1'b1);
		r.payload_bytes = '1;
		send_req(r);

		// zero rate and a frame length too short for any payload
		configure(CFG_W'(30'h3FFF_FFFF), '0, '0, CFG_W'(3));
		send_req(data_req('0));
		send_req(data_req(PAY_W'(8)));
		send_req(gap_req(GAP_W'(2), 1'b0));

		// header-only frame length takes an empty payload
		configure(CFG_W'(5), '0, '0, CFG_W'(4));
		send_req(data_req('0));
		send_req(data_req('0));

		configure('0, CFG_W'(2), CFG_W'(3), CFG_W'(5));
		send_req(data_req(PAY_W'(8)));
		send_req(data_req(PAY_W'(8)));
		send_req(data_req(PAY_W'(9)));
		send_req(gap_req(GAP_W'(5), 1'b1));
		send_req(data_req(PAY_W'(8)));

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 5))
				0: fps_v = FPS_W'(1);
				1: fps_v = FPS_W'(2);
				2: fps_v = FPS_W'(3);
				3: fps_v = FPS_W'($urandom_range(4, 1000));
				4: fps_v = 25'h100_0000;
				default: fps_v = '0;
			endcase
			case ($urandom_range(0, 3))
				0: frm_v = '0;
				1: frm_v = (fps_v == 0) ? '0 : FRM_W'(fps_v - 1'b1);
				2: frm_v = FRM_W'($urandom_range(0, fps_v));
				default: frm_v = '1;
			endcase
			case ($urandom_range(0, 3))
				0: sec_v = '0;
				1: sec_v = '1;
				2: sec_v = SEC_W'(30'h3FFF_FFF0);
				default: sec_v = SEC_W'($urandom);
			endcase
			case ($urandom_range(0, 4))
				0: flen_v = FLW_W'(5);
				1: flen_v = FLW_W'(1004);
				2: flen_v = FLW_W'($urandom_range(5, 24'hFF_FFFF));
				3: flen_v = '1;
				default: flen_v = FLW_W'($urandom_range(0, 4));
			endcase
			configure(sec_v, {6'($urandom), frm_v}, {5'($urandom), fps_v},
				{6'($urandom), flen_v});
			quiet = (ph == RANDOM_PHASES - 1);
			idle_pct = quiet ? 0 : 20 * $urandom_range(0, 2);
			stall_pct = quiet ? 0 : 20 * $urandom_range(0, 2);
			for (int n = 0; n < PHASE_REQS; n++) begin
				if (ph == 2 && n == PHASE_REQS / 2)
					drain(0);
				sel = $urandom_range(0, 99);
				if (sel < 55)
					r = data_req(good_payload());
				else if (sel < 60)
					r = data_req(PAY_W'($urandom));
				else if (sel < 65)
					r = data_req(good_payload() ^ PAY_W'(1 << $urandom_range(0, PAY_W - 1)));
				else if (sel < 90)
					r = gap_req(GAP_W'($urandom_range(0, 8)), 1'($urandom));
				else
					r = gap_req(GAP_W'($urandom_range(9, 127)), 1'($urandom));
				send_req(r);
			end
		end

		drain(SETTLE_CYCLES);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### vdif_frame_header_generator.f
src/vdifhg_pkg.sv
src/vdifhg_ctrl.sv
src/vdifhg_dp.sv
src/vdif_frame_header_generator.sv
sim/vdif_frame_header_checker.sv
sim/tb_vdif_frame_header_generator.sv
